/* hdl/ffha_pkg.sv */
`default_nettype none
package ffha_pkg;
    localparam int unsigned MaxChunks   = 64;
    localparam int unsigned HeaderBytes = 16;
    localparam int unsigned IdxW        = $clog2(MaxChunks);
    localparam int unsigned CntW        = $clog2(MaxChunks + 1);

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StNoFit   = 2'd1;
    localparam logic [1:0] StBadAddr = 2'd2;

    localparam logic FuncAlloc   = 1'b0;
    localparam logic FuncRelease = 1'b1;

    localparam logic [0:0] RegStart = 1'd0;
    localparam logic [0:0] RegSize  = 1'd1;

    typedef enum logic [3:0] {
        t_idle,
        t_scan_rd,
        t_scan_chk,
        t_shup_rd,
        t_shup_wr,
        t_split_wr,
        t_rel_prev_rd,
        t_rel_next_rd,
        t_rel_merge,
        t_shdn_rd,
        t_shdn_wr,
        t_done
    } t_state;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] len;
        logic        busy;
    } t_entry;
endpackage
`default_nettype wire

/* hdl/first_fit_heap_allocator_core.sv */
`default_nettype none
// channel  | ports                                        | direction
// ---------+----------------------------------------------+----------
// request  | i_start, o_busy, i_func, i_request_size,     | in
//          | i_block_address                              |
// result   | o_done, o_granted_address, o_status          | out
// config   | i_cfg_we, i_cfg_index, i_cfg_wdata           | in
//
// one request at a time, o_busy high from the accepting edge to the strobe;
// each chunk scanned is read, then checked, and each chunk shifted (up on a
// split, down on a merge) is read, then written; a release reads both
// neighbors, all paced by the chunk table's registered read; a config write
// rebuilds the table as at most one free chunk; i_rst_n is synchronous, active
// low; the result strobe lasts one cycle and cannot be held off by the receiver
module first_fit_heap_allocator_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic        i_func,
    input  wire logic [31:0] i_request_size,
    input  wire logic [31:0] i_block_address,
    output logic             o_done,
    output logic [31:0]      o_granted_address,
    output logic [1:0]       o_status,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_wdata
);
    import ffha_pkg::*;

    // chunk table memory, one entry per chunk in address order
    t_entry mem [MaxChunks];
    t_entry r_rd;
    logic [IdxW-1:0] rd_addr;
    logic rd_en;
    logic we;
    logic [IdxW-1:0] wr_addr;
    t_entry wr_data;

    always_ff @(posedge i_clk) begin
        if (we) mem[wr_addr] <= wr_data;
        if (rd_en) r_rd <= mem[rd_addr];
    end

    t_state r_state, n_state;
    logic [CntW-1:0] r_total, n_total;
    logic [CntW-1:0] r_idx, n_idx;      // current entry / shift cursor
    logic [CntW-1:0] r_hit, n_hit;      // entry found by the scan
    logic            r_func, n_func;
    logic [31:0]     r_req, n_req, r_addr, n_addr;
    t_entry          r_cur, n_cur;      // found entry (possibly merged)
    t_entry          r_ins, n_ins;      // entry to place at the end of a shift
    logic            r_nxt_merge, n_nxt_merge;
    logic [31:0]     r_out, n_out;
    logic [1:0]      r_st, n_st;
    logic [31:0]     r_rstart, r_rsize;
    logic            r_done, n_done;

    // reload of the heap on config write
    logic [31:0] cfg_start, cfg_size;
    always_comb begin
        cfg_start = r_rstart;
        cfg_size  = r_rsize;
        if (i_cfg_index == RegStart) cfg_start = i_cfg_wdata;
        else cfg_size = i_cfg_wdata;
    end

    logic [31:0] cur_usable;
    logic [32:0] need;
    assign cur_usable = r_rd.base + 32'(HeaderBytes);
    assign need = {1'b0, r_req} + 33'(HeaderBytes) + 33'd1;

    always_comb begin
        n_state = r_state; n_total = r_total; n_idx = r_idx; n_hit = r_hit;
        n_func = r_func; n_req = r_req; n_addr = r_addr; n_cur = r_cur;
        n_ins = r_ins; n_nxt_merge = r_nxt_merge; n_out = r_out; n_st = r_st;
        n_done = 1'b0;
        rd_en = 1'b0; rd_addr = r_idx[IdxW-1:0];
        we = 1'b0; wr_addr = r_idx[IdxW-1:0]; wr_data = r_cur;
        unique case (r_state)
            t_idle: begin
                if (i_start) begin
                    n_func = i_func; n_req = i_request_size; n_addr = i_block_address;
                    n_idx = '0; n_out = '0;
                    n_state = t_scan_rd;
                end
            end
            t_scan_rd: begin
                if (r_idx >= r_total) begin
                    n_st = (r_func == FuncAlloc) ? StNoFit : StBadAddr;
                    n_state = t_done;
                end else begin
                    rd_en = 1'b1;
                    n_state = t_scan_chk;
                end
            end
            t_scan_chk: begin
                n_hit = r_idx; n_cur = r_rd;
                if (r_func == FuncAlloc) begin
                    if (!r_rd.busy && r_rd.len > r_req) begin
                        n_out = cur_usable; n_st = StOk;
                        if ({1'b0, r_rd.len} >= need && r_total < CntW'(MaxChunks)) begin
                            n_ins.base = r_rd.base + 32'(HeaderBytes) + r_req;
                            n_ins.len = r_rd.len - r_req - 32'(HeaderBytes);
                            n_ins.busy = 1'b0;
                            n_cur.len = r_req;
                            n_cur.busy = 1'b1;
                            n_idx = r_total;
                            n_state = t_shup_rd;
                        end else begin
                            n_cur.busy = 1'b1;
                            n_state = t_split_wr;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1; n_state = t_scan_rd;
                    end
                end else begin
                    if (cur_usable == r_addr) begin
                        if (!r_rd.busy) begin
                            n_st = StBadAddr; n_state = t_done;
                        end else begin
                            n_st = StOk; n_cur.busy = 1'b0;
                            n_state = t_rel_prev_rd;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1; n_state = t_scan_rd;
                    end
                end
            end
            // open a hole at hit+1 by moving entries up, top first
            t_shup_rd: begin
                if (r_idx == r_hit + 1'b1) begin
                    we = 1'b1; wr_addr = r_idx[IdxW-1:0]; wr_data = r_ins;
                    n_total = r_total + 1'b1;
                    n_idx = r_hit;
                    n_state = t_split_wr;
                end else begin
                    rd_en = 1'b1; rd_addr = IdxW'(r_idx - 1'b1);
                    n_state = t_shup_wr;
                end
            end
            t_shup_wr: begin
                we = 1'b1; wr_addr = r_idx[IdxW-1:0]; wr_data = r_rd;
                n_idx = r_idx - 1'b1; n_state = t_shup_rd;
            end
            t_split_wr: begin
                we = 1'b1; wr_addr = r_hit[IdxW-1:0]; wr_data = r_cur;
                n_state = t_done;
            end
            // release: look at the left neighbor
            t_rel_prev_rd: begin
                if (r_hit != '0) begin
                    rd_en = 1'b1; rd_addr = IdxW'(r_hit - 1'b1);
                end
                n_state = t_rel_next_rd;
            end
            t_rel_next_rd: begin
                // merge into the left neighbor if free; removed entry is hit
                n_idx = '1; // marks no removal yet
                if (r_hit != '0 && !r_rd.busy) begin
                    n_cur.base = r_rd.base;
                    n_cur.len = r_rd.len + 32'(HeaderBytes) + r_cur.len;
                    n_hit = r_hit - 1'b1;
                end
                rd_en = 1'b1; rd_addr = IdxW'(r_hit + 1'b1);
                n_state = t_rel_merge;
                // remember whether a left merge happened
                n_nxt_merge = (r_hit != '0 && !r_rd.busy);
            end
            t_rel_merge: begin
                // r_rd is the right neighbor of the freed chunk
                // count of entries to remove starting after r_hit
                n_ins.busy = 1'b0;
                if (r_hit + 1'b1 + CntW'(r_nxt_merge) < r_total && !r_rd.busy) begin
                    n_cur.len = r_cur.len + 32'(HeaderBytes) + r_rd.len;
                    n_ins.busy = 1'b1; // right merge too
                end
                n_idx = r_hit + 1'b1;
                // shift distance in r_req
                n_req = 32'(r_nxt_merge) + 32'(n_ins.busy);
                // no merge leaves the table order as it is
                n_state = (n_req == '0) ? t_split_wr : t_shdn_rd;
            end
            // close the gap by moving entries down
            t_shdn_rd: begin
                if (r_idx + CntW'(r_req) >= r_total) begin
                    n_total = r_total - CntW'(r_req);
                    n_state = t_split_wr;
                end else begin
                    rd_en = 1'b1; rd_addr = IdxW'(r_idx + CntW'(r_req));
                    n_state = t_shdn_wr;
                end
            end
            t_shdn_wr: begin
                we = 1'b1; wr_addr = r_idx[IdxW-1:0]; wr_data = r_rd;
                n_idx = r_idx + 1'b1; n_state = t_shdn_rd;
            end
            t_done: begin
                n_done = 1'b1; n_state = t_idle;
            end
            default: n_state = t_idle;
        endcase
        if (i_cfg_we) begin
            we = 1'b1; wr_addr = '0;
            wr_data.base = cfg_start;
            wr_data.len = cfg_size - 32'(HeaderBytes);
            wr_data.busy = 1'b0;
            n_total = (cfg_size >= 32'(HeaderBytes)) ? CntW'(1) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_idle; r_total <= '0; r_done <= 1'b0;
            r_rstart <= '0; r_rsize <= '0;
        end else begin
            r_state <= n_state; r_total <= n_total; r_done <= n_done;
            if (i_cfg_we) begin
                r_rstart <= cfg_start; r_rsize <= cfg_size;
            end
        end
        r_idx <= n_idx; r_hit <= n_hit; r_func <= n_func; r_req <= n_req;
        r_addr <= n_addr; r_cur <= n_cur; r_ins <= n_ins;
        r_nxt_merge <= n_nxt_merge; r_out <= n_out; r_st <= n_st;
    end

    assign o_busy = (r_state != t_idle);
    assign o_done = r_done;
    assign o_granted_address = r_out;
    assign o_status = r_st;
endmodule
`default_nettype wire
